### rtl/palette_gradient_fill_engine_unit_assert.svh
// assertion macros for the palette gradient fill engine
`ifndef PALETTE_GRADIENT_FILL_ENGINE_UNIT_ASSERT_SVH
`define PALETTE_GRADIENT_FILL_ENGINE_UNIT_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define PGF_ASSERT_SAME(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("pgf assertion failed");

// condition holds in the cycle after the trigger
`define PGF_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("pgf assertion failed");

`endif

### rtl/pgf_pkg.sv
// shared types, constants and color helpers of the palette gradient fill engine
`default_nettype none

package pgf_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int IDX_W   = 8;
  localparam int IN_CH_W = 8;
  localparam int CH_W    = 5;
  localparam int COLOR_W = 3 * CH_W;
  localparam int FRAC_W  = 16;
  localparam int ACC_W   = 26;
  localparam int INT_W   = ACC_W - FRAC_W;
  localparam int QUO_W   = IDX_W + FRAC_W;
  localparam int NUM_CH  = 3;
  localparam logic [CH_W-1:0] CH_MAX = 5'd31;

  typedef enum logic [1:0] {
    CMD_SET       = 2'd0,
    CMD_GRAD      = 2'd1,
    CMD_GRAD_PREV = 2'd2,
    CMD_READ      = 2'd3
  } cmd_t;

  // clamp an integer channel to 0..31
  function automatic logic [CH_W-1:0] clamp_ch(input logic signed [INT_W-1:0] v);
    logic [CH_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > INT_W'(signed'({1'b0, CH_MAX}))) begin
      r = CH_MAX;
    end else begin
      r = v[CH_W-1:0];
    end
    return r;
  endfunction

  // red in the top bits, blue in the bottom
  function automatic logic [COLOR_W-1:0] pack(input logic [CH_W-1:0] r,
                                              input logic [CH_W-1:0] g,
                                              input logic [CH_W-1:0] b);
    return {r, g, b};
  endfunction

endpackage

`default_nettype wire

### rtl/palette_gradient_fill_engine_unit.sv
// palette gradient fill engine: palette memory, step dividers and fill sequencer
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_ready, in_cmd, indexes,    | input
//           | start and end channels                  |
//   out     | out_valid, out_ready, out_read_color,   | output
//           | out_status                              |
//
// one transaction at a time; a set, or from previous at entry zero, runs exec and finish,
// a read or a reversed gradient adds a read wait or a setup (reversed from previous both),
// a gradient runs setup, the 24-step bit-serial divider unless the span is zero, then fills
// every entry of the span through the one-write-per-cycle port; from previous adds a read wait.
// after reset a clearing pass writes zero to all PALETTE_ENTRIES entries, one per cycle.
// results wait in one output register; the last cycle repeats while it is full and stalled
`default_nettype none

`include "palette_gradient_fill_engine_unit_assert.svh"

module palette_gradient_fill_engine_unit #(
  parameter int PALETTE_ENTRIES = pgf_pkg::PALETTE_ENTRIES_DEF
) (
  input  wire                                      clk,
  input  wire                                      rst_n,
  input  wire                                      in_valid,
  output logic                                     in_ready,
  input  wire  [1:0]                               in_cmd,
  input  wire  [pgf_pkg::IDX_W-1:0]                in_first_index,
  input  wire  [pgf_pkg::IDX_W-1:0]                in_last_index,
  input  wire  signed [pgf_pkg::IN_CH_W-1:0]       in_start_red,
  input  wire  signed [pgf_pkg::IN_CH_W-1:0]       in_start_green,
  input  wire  signed [pgf_pkg::IN_CH_W-1:0]       in_start_blue,
  input  wire  signed [pgf_pkg::IN_CH_W-1:0]       in_end_red,
  input  wire  signed [pgf_pkg::IN_CH_W-1:0]       in_end_green,
  input  wire  signed [pgf_pkg::IN_CH_W-1:0]       in_end_blue,
  output logic                                     out_valid,
  input  wire                                      out_ready,
  output logic [pgf_pkg::COLOR_W-1:0]              out_read_color,
  output logic                                     out_status
);

  localparam int AW     = $clog2(PALETTE_ENTRIES);
  localparam int IDX_W  = pgf_pkg::IDX_W;
  localparam int CH_W   = pgf_pkg::CH_W;
  localparam int COL_W  = pgf_pkg::COLOR_W;
  localparam int ACC_W  = pgf_pkg::ACC_W;
  localparam int FRAC_W = pgf_pkg::FRAC_W;
  localparam int INT_W  = pgf_pkg::INT_W;
  localparam int QUO_W  = pgf_pkg::QUO_W;
  localparam int NCH    = pgf_pkg::NUM_CH;
  localparam int DIFF_W = pgf_pkg::IN_CH_W + 1;
  localparam int CNT_W  = $clog2(QUO_W);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_SETUP,
    ST_DIV,
    ST_FILL,
    ST_FIN
  } state_t;

  // index lies inside the palette
  function automatic logic in_rng(input logic [IDX_W-1:0] i);
    return 32'(i) < 32'(PALETTE_ENTRIES);
  endfunction

  state_t                     state_r;
  logic [AW-1:0]              clr_addr_r;
  pgf_pkg::cmd_t              cmd_r;
  logic [IDX_W-1:0]           first_r;
  logic [IDX_W-1:0]           last_r;
  logic signed [pgf_pkg::IN_CH_W-1:0] st_r [NCH];
  logic signed [pgf_pkg::IN_CH_W-1:0] en_r [NCH];
  logic signed [DIFF_W-1:0]   s_r [NCH];
  logic [IDX_W-1:0]           c0_r;
  logic [IDX_W-1:0]           idx_r;
  logic [IDX_W-1:0]           span_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [QUO_W-1:0]           dvd_r [NCH];
  logic [IDX_W-1:0]           rem_r [NCH];
  logic [QUO_W-1:0]           quo_r [NCH];
  logic                       neg_r [NCH];
  logic signed [ACC_W-1:0]    step_r [NCH];
  logic signed [ACC_W-1:0]    acc_r [NCH];
  logic [COL_W-1:0]           res_color_r;
  logic                       res_status_r;
  logic                       out_valid_r;
  logic [COL_W-1:0]           out_color_r;
  logic                       out_status_r;

  logic [COL_W-1:0]           palette_mem [PALETTE_ENTRIES];
  logic [COL_W-1:0]           rd_data_r;
  logic [AW-1:0]              mem_raddr;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [COL_W-1:0]           mem_wdata;

  logic [IDX_W:0]             rem_sh [NCH];
  logic [IDX_W-1:0]           rem_nxt [NCH];
  logic [QUO_W-1:0]           quo_nxt [NCH];
  logic signed [ACC_W-1:0]    step_nxt [NCH];
  logic signed [DIFF_W-1:0]   diff [NCH];
  logic [DIFF_W-1:0]          diff_mag [NCH];
  logic [CH_W-1:0]            fill_ch [NCH];
  logic [CH_W-1:0]            set_ch [NCH];
  logic                       out_free;

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_read_color = out_color_r;
  assign out_status     = out_status_r;
  assign out_free       = !out_valid_r || out_ready;

  // divider step, step sign, channel differences and clamped channels
  always_comb begin
    for (int l = 0; l < NCH; l++) begin
      rem_sh[l] = {rem_r[l], dvd_r[l][QUO_W-1]};
      if (rem_sh[l] >= {1'b0, span_r}) begin
        rem_nxt[l] = IDX_W'(rem_sh[l] - {1'b0, span_r});
        quo_nxt[l] = {quo_r[l][QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt[l] = rem_sh[l][IDX_W-1:0];
        quo_nxt[l] = {quo_r[l][QUO_W-2:0], 1'b0};
      end
      step_nxt[l] = neg_r[l] ? (ACC_W'(0) - signed'(ACC_W'(quo_nxt[l])))
                             : signed'(ACC_W'(quo_nxt[l]));
      diff[l]     = signed'({en_r[l][pgf_pkg::IN_CH_W-1], en_r[l]}) - s_r[l];
      diff_mag[l] = diff[l][DIFF_W-1] ? DIFF_W'(-diff[l]) : DIFF_W'(diff[l]);
      fill_ch[l]  = pgf_pkg::clamp_ch(acc_r[l][ACC_W-1:FRAC_W]);
      set_ch[l]   = pgf_pkg::clamp_ch(INT_W'(st_r[l]));
    end
  end

  // memory read address and write port
  always_comb begin
    mem_raddr = (cmd_r == pgf_pkg::CMD_GRAD_PREV) ? AW'(first_r - IDX_W'(1)) : AW'(first_r);
    mem_we    = 1'b0;
    mem_waddr = AW'(idx_r);
    mem_wdata = pgf_pkg::pack(fill_ch[0], fill_ch[1], fill_ch[2]);
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = '0;
      end
      ST_EXEC: begin
        if (cmd_r == pgf_pkg::CMD_SET && in_rng(first_r)) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(first_r);
          mem_wdata = pgf_pkg::pack(set_ch[0], set_ch[1], set_ch[2]);
        end
      end
      ST_FILL: begin
        mem_we = in_rng(idx_r);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // palette memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      palette_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= palette_mem[mem_raddr];
  end

  // command sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // taken result leaves, unless a new one loads in the same cycle
      if (out_valid_r && out_ready && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(PALETTE_ENTRIES - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            cmd_r    <= pgf_pkg::cmd_t'(in_cmd);
            first_r  <= in_first_index;
            last_r   <= in_last_index;
            st_r[0]  <= in_start_red;
            st_r[1]  <= in_start_green;
            st_r[2]  <= in_start_blue;
            en_r[0]  <= in_end_red;
            en_r[1]  <= in_end_green;
            en_r[2]  <= in_end_blue;
            state_r  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_color_r  <= '0;
          res_status_r <= 1'b0;
          case (cmd_r)
            pgf_pkg::CMD_SET: begin
              state_r <= ST_FIN;
            end
            pgf_pkg::CMD_GRAD: begin
              c0_r <= first_r;
              for (int l = 0; l < NCH; l++) begin
                s_r[l] <= DIFF_W'(st_r[l]);
              end
              state_r <= ST_SETUP;
            end
            pgf_pkg::CMD_GRAD_PREV: begin
              if (first_r == '0) begin
                res_status_r <= 1'b1;
                state_r      <= ST_FIN;
              end else begin
                c0_r    <= first_r - IDX_W'(1);
                state_r <= ST_RDWAIT;
              end
            end
            pgf_pkg::CMD_READ: begin
              c0_r    <= first_r;
              state_r <= ST_RDWAIT;
            end
            default: begin
              state_r <= ST_FIN;
            end
          endcase
        end
        ST_RDWAIT: begin
          if (cmd_r == pgf_pkg::CMD_READ) begin
            res_color_r <= in_rng(c0_r) ? rd_data_r : '0;
            state_r     <= ST_FIN;
          end else begin
            // start color comes from the previous entry
            s_r[0]  <= in_rng(c0_r) ? DIFF_W'(rd_data_r[COL_W-1:2*CH_W]) : '0;
            s_r[1]  <= in_rng(c0_r) ? DIFF_W'(rd_data_r[2*CH_W-1:CH_W]) : '0;
            s_r[2]  <= in_rng(c0_r) ? DIFF_W'(rd_data_r[CH_W-1:0]) : '0;
            state_r <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          span_r <= last_r - c0_r;
          idx_r  <= c0_r;
          cnt_r  <= '0;
          for (int l = 0; l < NCH; l++) begin
            dvd_r[l]  <= {diff_mag[l][IDX_W-1:0], FRAC_W'(0)};
            rem_r[l]  <= '0;
            quo_r[l]  <= '0;
            neg_r[l]  <= diff[l][DIFF_W-1];
            step_r[l] <= '0;
            acc_r[l]  <= {s_r[l][DIFF_W-1], s_r[l], FRAC_W'(0)};
          end
          if (last_r < c0_r) begin
            state_r <= ST_FIN;
          end else if (last_r == c0_r) begin
            state_r <= ST_FILL;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          cnt_r <= cnt_r + CNT_W'(1);
          for (int l = 0; l < NCH; l++) begin
            dvd_r[l] <= {dvd_r[l][QUO_W-2:0], 1'b0};
            rem_r[l] <= rem_nxt[l];
            quo_r[l] <= quo_nxt[l];
          end
          if (cnt_r == CNT_W'(QUO_W - 1)) begin
            for (int l = 0; l < NCH; l++) begin
              step_r[l] <= step_nxt[l];
            end
            state_r <= ST_FILL;
          end
        end
        ST_FILL: begin
          for (int l = 0; l < NCH; l++) begin
            acc_r[l] <= acc_r[l] + step_r[l];
          end
          if (idx_r == last_r) begin
            state_r <= ST_FIN;
          end else begin
            idx_r <= idx_r + IDX_W'(1);
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_color_r  <= res_color_r;
            out_status_r <= res_status_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // no memory write while waiting for a transaction
  `PGF_ASSERT_SAME(a_idle_no_write, clk, rst_n, state_r == ST_IDLE, !mem_we)
  // fill address stays inside the requested range
  `PGF_ASSERT_SAME(a_fill_range, clk, rst_n, state_r == ST_FILL,
                   (idx_r >= c0_r) && (idx_r <= last_r))
  // divider runs only with a nonzero span
  `PGF_ASSERT_SAME(a_div_span, clk, rst_n, state_r == ST_DIV, span_r != '0)
  // a finished result is presented on the next cycle
  `PGF_ASSERT_NEXT(a_fin_out, clk, rst_n, (state_r == ST_FIN) && out_free,
                   out_valid_r && (state_r == ST_IDLE))
  // error status never comes with read data
  `PGF_ASSERT_SAME(a_status_color, clk, rst_n, out_valid_r && out_status_r, out_color_r == '0)

endmodule

`default_nettype wire
